FILE: rtl/csr_pkg.sv
package csr_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_SIZE = 32;
	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int LEN_W = 6;
	localparam int BYTE_DEPTH = SLOT_COUNT * SLOT_SIZE;
	localparam int BYTE_AW = $clog2(BYTE_DEPTH);

	typedef enum logic [2:0] {
		OP_WRITE      = 3'd0,
		OP_COMMIT     = 3'd1,
		OP_SET_FLAG   = 3'd2,
		OP_READ       = 3'd3,
		OP_FLUSH_SLOT = 3'd4,
		OP_FLUSH_ALL  = 3'd5
	} op_t;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] slot;
		logic       flag_value;
		logic [7:0] char_in;
		logic [4:0] position;
	} cmd_t;

	typedef struct packed {
		logic             accepted;
		logic [7:0]       read_byte;
		logic [LEN_W-1:0] slot_length;
		logic             slot_ready;
		logic             slot_overflow;
		logic             found_ready;
		logic [2:0]       oldest_index;
		logic [2:0]       active_slot;
	} rsp_t;

endpackage

FILE: rtl/csr_if.sv
interface csr_cmd_if import csr_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface csr_rsp_if import csr_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/csr_ram.sv
module csr_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/command_slot_ring_core.sv
// An item is accepted when the core is idle and completes once the output register is empty
// or its result is taken; no new item is accepted before then. The byte and length memories
// are read first; then they are modified and written back and the output register is loaded.
// A new item is accepted while a finished result still waits in the output register.
// Reset clears the active slot, ready, overflow and length-valid bits and the handshake
// state at once; the byte memory is not cleared.
module command_slot_ring_core import csr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	csr_cmd_if.sink   cmd,
	csr_rsp_if.source rsp
);

	logic                  busy_q;
	idx_t                  act_q;
	logic [SLOT_COUNT-1:0] rdy_q;
	logic [SLOT_COUNT-1:0] ovf_q;
	logic [SLOT_COUNT-1:0] len_vld_q;
	logic                  out_vld_q;
	rsp_t                  out_q;

	cmd_t                  cmd_s1;
	logic                  slot_ok_s1;
	logic                  len_vld_s1;

	logic                  accept;
	logic                  done;
	idx_t                  slot_in;
	idx_t                  len_raddr;
	logic [BYTE_AW-1:0]    byte_raddr;
	logic [LEN_W-1:0]      len_rd;
	logic [7:0]            byte_rd;

	idx_t                  slot_i;
	idx_t                  act_inc;
	idx_t                  act_n;
	logic [LEN_W-1:0]      len_cur;
	logic [LEN_W-1:0]      act_len;
	logic [SLOT_COUNT-1:0] rdy_n;
	logic [SLOT_COUNT-1:0] ovf_n;
	logic [SLOT_COUNT-1:0] vld_n;
	logic                  byte_we;
	logic [BYTE_AW-1:0]    byte_waddr;
	logic                  len_we;
	idx_t                  len_waddr;
	logic [LEN_W-1:0]      len_wdata;
	logic                  found;
	idx_t                  oldest;
	logic [IDX_W:0]        scan;
	rsp_t                  rsp_d;

	assign cmd.ready = !busy_q;
	assign accept = cmd.valid && cmd.ready;
	assign done = busy_q && (!out_vld_q || rsp.ready);
	assign rsp.valid = out_vld_q;
	assign rsp.data = out_q;

	assign slot_in = IDX_W'(cmd.data.slot);
	assign len_raddr = (cmd.data.op == OP_READ) ? slot_in : act_q;
	assign byte_raddr = BYTE_AW'(BYTE_AW'(slot_in) * BYTE_AW'(SLOT_SIZE))
		+ BYTE_AW'(cmd.data.position);

	csr_ram #(
		.DEPTH(BYTE_DEPTH),
		.WIDTH(8)
	) u_byte_ram (
		.clk  (clk),
		.we   (done && byte_we),
		.waddr(byte_waddr),
		.wdata(cmd_s1.char_in),
		.re   (accept),
		.raddr(byte_raddr),
		.rdata(byte_rd)
	);

	csr_ram #(
		.DEPTH(SLOT_COUNT),
		.WIDTH(LEN_W)
	) u_len_ram (
		.clk  (clk),
		.we   (done && len_we),
		.waddr(len_waddr),
		.wdata(len_wdata),
		.re   (accept),
		.raddr(len_raddr),
		.rdata(len_rd)
	);

	always_comb begin
		slot_i = IDX_W'(cmd_s1.slot);
		act_inc = (act_q == IDX_W'(SLOT_COUNT - 1)) ? '0 : act_q + 1'b1;
		len_cur = len_vld_s1 ? len_rd : '0;
		act_n = act_q;
		rdy_n = rdy_q;
		ovf_n = ovf_q;
		vld_n = len_vld_q;
		byte_we = 1'b0;
		byte_waddr = BYTE_AW'(BYTE_AW'(act_q) * BYTE_AW'(SLOT_SIZE)) + BYTE_AW'(len_cur);
		len_we = 1'b0;
		len_waddr = act_q;
		len_wdata = '0;
		rsp_d = '0;

		case (op_t'(cmd_s1.op))
			OP_WRITE: begin
				if (len_cur >= LEN_W'(SLOT_SIZE)) begin
					ovf_n[act_q] = 1'b1;
				end else begin
					byte_we = 1'b1;
					len_we = 1'b1;
					len_wdata = len_cur + 1'b1;
					rsp_d.accepted = 1'b1;
				end
			end
			OP_COMMIT: begin
				rdy_n[act_q] = 1'b1;
				act_n = act_inc;
				len_we = 1'b1;
				len_waddr = act_inc;
			end
			OP_SET_FLAG: begin
				if (slot_ok_s1) begin
					rdy_n[slot_i] = cmd_s1.flag_value;
				end
			end
			OP_READ: begin
				if (slot_ok_s1 && ({1'b0, cmd_s1.position} < len_cur)) begin
					rsp_d.read_byte = byte_rd;
				end
			end
			OP_FLUSH_SLOT: begin
				if (slot_ok_s1) begin
					len_we = 1'b1;
					len_waddr = slot_i;
				end
			end
			OP_FLUSH_ALL: begin
				act_n = '0;
				rdy_n = '0;
				ovf_n = '0;
				vld_n = '0;
			end
			default: begin
			end
		endcase

		if (len_we) begin
			vld_n[len_waddr] = 1'b1;
		end

		if (len_we && (len_waddr == act_n)) begin
			act_len = len_wdata;
		end else if (cmd_s1.op == OP_FLUSH_ALL) begin
			act_len = '0;
		end else begin
			act_len = len_cur;
		end

		if ((cmd_s1.op == OP_SET_FLAG) || (cmd_s1.op == OP_READ)
			|| (cmd_s1.op == OP_FLUSH_SLOT)) begin
			if (slot_ok_s1) begin
				rsp_d.slot_ready = rdy_n[slot_i];
				rsp_d.slot_overflow = ovf_n[slot_i];
				rsp_d.slot_length = (cmd_s1.op == OP_READ) ? len_cur : act_len;
			end else begin
				rsp_d.slot_length = (cmd_s1.op == OP_READ) ? '0 : act_len;
			end
		end else begin
			rsp_d.slot_ready = rdy_n[act_n];
			rsp_d.slot_overflow = ovf_n[act_n];
			rsp_d.slot_length = act_len;
		end

		found = 1'b0;
		oldest = act_n;
		for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
			scan = (IDX_W + 1)'(act_n) + (IDX_W + 1)'(k + 1);
			if (scan >= (IDX_W + 1)'(SLOT_COUNT)) begin
				scan = scan - (IDX_W + 1)'(SLOT_COUNT);
			end
			if (rdy_n[IDX_W'(scan)]) begin
				found = 1'b1;
				oldest = IDX_W'(scan);
			end
		end

		rsp_d.found_ready = found;
		rsp_d.oldest_index = 3'(oldest);
		rsp_d.active_slot = 3'(act_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			act_q <= '0;
			rdy_q <= '0;
			ovf_q <= '0;
			len_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				act_q <= act_n;
				rdy_q <= rdy_n;
				ovf_q <= ovf_n;
				len_vld_q <= vld_n;
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd.data;
			slot_ok_s1 <= (int'(cmd.data.slot) < SLOT_COUNT);
			len_vld_s1 <= len_vld_q[len_raddr];
		end
		if (done) begin
			out_q <= rsp_d;
		end
	end

	a_accept_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.accepted |-> out_q.slot_length != '0)
		else $error("stored byte reported with zero length");

	a_oldest_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_q.found_ready |-> out_q.oldest_index == out_q.active_slot)
		else $error("oldest index differs from active slot with no ready slot");

	a_read_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (out_q.read_byte != '0) |-> out_q.slot_length != '0)
		else $error("byte returned from an empty slot");

	a_done_seq: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_vld_q && !busy_q)
		else $error("completed item did not reach the output register");

	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, act_q} < (IDX_W + 1)'(SLOT_COUNT))
		else $error("active slot out of range");

endmodule

FILE: tb/sv/csr_ring_checker.sv
`timescale 1ns / 100ps

module csr_ring_checker import csr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	csr_cmd_if   cmd,
	csr_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);

	logic [7:0]       line_bytes [SLOT_COUNT][SLOT_SIZE];
	logic [LEN_W-1:0] line_len   [SLOT_COUNT];
	bit               line_ready [SLOT_COUNT];
	bit               line_ovf   [SLOT_COUNT];
	idx_t             write_slot;
	rsp_t             expected_rsp_q [$];
	rsp_t             want;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic idx_t next_slot(input idx_t i);
		return (int'(i) == SLOT_COUNT - 1) ? idx_t'(0) : idx_t'(i + 1'b1);
	endfunction

	function automatic rsp_t predict_rsp(input cmd_t c);
		rsp_t r;
		idx_t s;
		idx_t j;
		bit   slot_ok;
		r = '0;
		s = idx_t'(c.slot);
		slot_ok = int'(c.slot) < SLOT_COUNT;
		case (c.op)
			OP_WRITE: begin
				if (line_len[write_slot] >= SLOT_SIZE) begin
					line_ovf[write_slot] = 1'b1;
				end else begin
					line_bytes[write_slot][line_len[write_slot]] = c.char_in;
					line_len[write_slot] = line_len[write_slot] + 1'b1;
					r.accepted = 1'b1;
				end
			end
			OP_COMMIT: begin
				line_ready[write_slot] = 1'b1;
				write_slot = next_slot(write_slot);
				line_len[write_slot] = '0;
			end
			OP_SET_FLAG: begin
				if (slot_ok) line_ready[s] = c.flag_value;
			end
			OP_READ: begin
				if (slot_ok && c.position < line_len[s])
					r.read_byte = line_bytes[s][c.position];
			end
			OP_FLUSH_SLOT: begin
				if (slot_ok) line_len[s] = '0;
			end
			OP_FLUSH_ALL: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					line_len[i] = '0;
					line_ready[i] = 1'b0;
					line_ovf[i] = 1'b0;
				end
				write_slot = '0;
			end
			default: begin
			end
		endcase

		if (c.op == OP_SET_FLAG || c.op == OP_READ || c.op == OP_FLUSH_SLOT) begin
			if (slot_ok) begin
				r.slot_ready = line_ready[s];
				r.slot_overflow = line_ovf[s];
				r.slot_length = (c.op == OP_READ) ? line_len[s] : line_len[write_slot];
			end else begin
				r.slot_length = (c.op == OP_READ) ? '0 : line_len[write_slot];
			end
		end else begin
			r.slot_ready = line_ready[write_slot];
			r.slot_overflow = line_ovf[write_slot];
			r.slot_length = line_len[write_slot];
		end

		r.oldest_index = write_slot;
		j = next_slot(write_slot);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!r.found_ready && line_ready[j]) begin
				r.found_ready = 1'b1;
				r.oldest_index = j;
			end
			j = next_slot(j);
		end
		r.active_slot = write_slot;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				line_len[i] = '0;
				line_ready[i] = 1'b0;
				line_ovf[i] = 1'b0;
			end
			write_slot = '0;
			expected_rsp_q.delete();
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("result item arrived with no command outstanding");
				end else begin
					want = expected_rsp_q.pop_front();
					check_field("accepted", rsp.data.accepted, want.accepted);
					check_field("read_byte", rsp.data.read_byte, want.read_byte);
					check_field("slot_length", rsp.data.slot_length, want.slot_length);
					check_field("slot_ready", rsp.data.slot_ready, want.slot_ready);
					check_field("slot_overflow", rsp.data.slot_overflow, want.slot_overflow);
					check_field("found_ready", rsp.data.found_ready, want.found_ready);
					check_field("oldest_index", rsp.data.oldest_index, want.oldest_index);
					check_field("active_slot", rsp.data.active_slot, want.active_slot);
				end
			end
			if (cmd.valid && cmd.ready)
				expected_rsp_q.push_back(predict_rsp(cmd.data));
			pending = expected_rsp_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_command_slot_ring_core.sv
`timescale 1ns / 100ps

module tb_command_slot_ring_core import csr_pkg::*; ();

	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam int RANDOM_ITEMS = 580;
	localparam int LONG_STALL = 300;
	localparam int CYCLE_LIMIT = 250000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	csr_cmd_if cmd();
	csr_rsp_if rsp();

	int fails;
	int pending;
	int cycles = 0;
	int sent = 0;
	int source_idle_pct = 22;
	int sink_idle_pct = 87;
	int stall_reqs = 0;
	int stall_seen = 0;
	int stall_left = 0;
	logic ready_next;

	command_slot_ring_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	csr_ring_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rsp        (rsp),
		.fail_count (fails),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_command_slot_ring_core NOT OK");
			$finish;
		end
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_reqs != stall_seen) begin
				stall_seen = stall_reqs;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0) begin
				stall_left--;
				ready_next = 1'b0;
			end else begin
				ready_next = $urandom_range(99) >= sink_idle_pct;
			end
			@(negedge clk);
			rsp.ready <= ready_next;
		end
	end

	function automatic cmd_t make_cmd(input logic [2:0] op, input logic [2:0] slot,
			input logic flag, input logic [7:0] ch, input logic [4:0] pos);
		cmd_t c;
		c.op = op;
		c.slot = slot;
		c.flag_value = flag;
		c.char_in = ch;
		c.position = pos;
		return c;
	endfunction

	function automatic cmd_t rand_cmd(input logic [2:0] op);
		logic [4:0] pos;
		pos = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(15));
		return make_cmd(op, 3'($urandom_range(7)), 1'($urandom_range(1)),
			8'($urandom_range(255)), pos);
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_cmd(input cmd_t c);
		while ($urandom_range(99) < source_idle_pct) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.data <= c;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic wait_drain();
		cmd.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	initial begin
		int pick;
		int n;
		bit stall_one_done;
		bit stall_two_done;
		bit drain_done;
		stall_one_done = 0;
		stall_two_done = 0;
		drain_done = 0;
		cmd.valid = 1'b0;
		cmd.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_cmd(make_cmd(OP_READ, 3'd0, 1'b0, 8'h00, 5'd0));
		send_cmd(make_cmd(OP_WRITE, 3'd7, 1'b1, 8'h00, 5'd31));
		send_cmd(make_cmd(OP_WRITE, 3'd0, 1'b0, 8'hFF, 5'd0));
		send_cmd(make_cmd(OP_WRITE, 3'd5, 1'b1, 8'h5A, 5'd17));
		send_cmd(make_cmd(OP_READ, 3'd0, 1'b0, 8'h00, 5'd0));
		send_cmd(make_cmd(OP_READ, 3'd0, 1'b0, 8'h00, 5'd2));
		send_cmd(make_cmd(OP_READ, 3'd0, 1'b0, 8'h00, 5'd3));
		send_cmd(make_cmd(OP_READ, 3'd0, 1'b1, 8'hFF, 5'd31));
		send_cmd(make_cmd(OP_SET_FLAG, 3'd7, 1'b1, 8'h00, 5'd0));
		send_cmd(make_cmd(OP_SET_FLAG, 3'd3, 1'b1, 8'h00, 5'd0));
		send_cmd(make_cmd(OP_COMMIT, 3'd0, 1'b0, 8'h00, 5'd0));
		send_cmd(make_cmd(OP_SET_FLAG, 3'd7, 1'b0, 8'h00, 5'd0));
		send_cmd(make_cmd(OP_READ, 3'd0, 1'b0, 8'h00, 5'd1));
		send_cmd(make_cmd(OP_FLUSH_SLOT, 3'd0, 1'b0, 8'h00, 5'd0));
		send_cmd(make_cmd(OP_READ, 3'd0, 1'b0, 8'h00, 5'd0));
		send_cmd(make_cmd(OP_SPARE_6, 3'd7, 1'b1, 8'hFF, 5'd31));
		send_cmd(make_cmd(OP_SPARE_7, 3'd0, 1'b0, 8'h00, 5'd0));
		send_cmd(make_cmd(OP_WRITE, 3'd2, 1'b0, 8'h81, 5'd9));
		send_cmd(make_cmd(OP_FLUSH_ALL, 3'd6, 1'b1, 8'h3C, 5'd12));
		send_cmd(make_cmd(OP_READ, 3'd1, 1'b0, 8'h00, 5'd0));

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (!stall_one_done && sent >= 120) begin
				stall_one_done = 1;
				stall_reqs++;
			end
			if (sent >= 200 && sent < 400) begin
				source_idle_pct = 87;
				sink_idle_pct = 22;
			end
			if (!drain_done && sent >= 300) begin
				drain_done = 1;
				wait_drain();
			end
			if (sent >= 400) begin
				source_idle_pct = 0;
				sink_idle_pct = 0;
			end
			if (!stall_two_done && sent >= 450) begin
				stall_two_done = 1;
				stall_reqs++;
			end

			pick = $urandom_range(99);
			if (pick < 50) begin
				n = ($urandom_range(7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 16);
				repeat (n) send_cmd(rand_cmd(OP_WRITE));
				if ($urandom_range(9) != 0) send_cmd(rand_cmd(OP_COMMIT));
				repeat ($urandom_range(3)) send_cmd(rand_cmd(OP_READ));
			end else if (pick < 65) begin
				send_cmd(rand_cmd(OP_READ));
			end else if (pick < 75) begin
				send_cmd(rand_cmd(OP_SET_FLAG));
			end else if (pick < 83) begin
				send_cmd(rand_cmd(OP_FLUSH_SLOT));
			end else if (pick < 86) begin
				send_cmd(rand_cmd(OP_FLUSH_ALL));
			end else if (pick < 90) begin
				send_cmd(rand_cmd($urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7));
			end else begin
				send_cmd(rand_cmd(3'($urandom_range(7))));
			end
		end

		wait_drain();
		repeat (8) @(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("tb_command_slot_ring_core OK");
		end else begin
			$display("tb_command_slot_ring_core NOT OK");
		end
		$finish;
	end

endmodule
